>>> hdl/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared types, constants and helpers for the neighbor table with TTL aging.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int SWP_W      = $clog2(TABLE_SIZE + 1);

  localparam int ID_W   = 6;
  localparam int GRP_W  = 8;
  localparam int LIFE_W = 8;
  localparam int TAG_W  = 9;
  localparam int CNT_W  = 11;
  localparam int CFG_W  = 10;
  localparam int QUO_W  = 8;

  localparam logic [GRP_W-1:0] NONE_GROUP = 8'hFF;

  // counter / 10 as (counter * 1639) >> 14, exact for any 11-bit counter
  localparam logic [CNT_W-1:0] DIV10_MUL   = 11'd1639;
  localparam int               DIV10_SHIFT = 14;

  localparam logic [ID_W-1:0]   RST_OWN_ID        = 6'd0;
  localparam logic [LIFE_W-1:0] RST_LIVE_TICKS    = 8'd200;
  localparam logic [CFG_W-1:0]  RST_COUNT_MAX     = 10'd100;
  localparam logic [CFG_W-1:0]  RST_COUNTER_START = 10'd0;

  typedef enum logic [1:0] {
    MODE_MSG   = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_OWN   = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CFG_OWN_ID        = 2'd0,
    CFG_LIVE_TICKS    = 2'd1,
    CFG_COUNT_MAX     = 2'd2,
    CFG_COUNTER_START = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic latch;       // capture the accepted item
    logic msg_wr;      // apply a received message
    logic own_wr;      // set own group, refresh own entry
    logic q_rd;        // read the queried entry
    logic t_div;       // register counter / 10
    logic t_cnt;       // advance counter, decide broadcast, arm sweep
    logic sweep;       // one aging step
    logic emit_zero;   // result with all fields zero
    logic emit_query;  // query result
    logic emit_tick;   // tick result
  } cmd_t;

  typedef struct packed {
    logic sweep_done;
  } status_t;

  function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] id);
    return IDX_W'(id);
  endfunction

endpackage

>>> hdl/ntt_ctrl.sv
// ----------------------------------------------------------------------------
// ntt_ctrl
// Controller: sequences messages, own-group changes, queries and the aging
// sweep of a tick.
// ----------------------------------------------------------------------------
module ntt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [1:0]      mode_i,
  input  ntt_pkg::status_t status_i,
  output ntt_pkg::cmd_t   cmd_o,
  output logic            busy
);
  import ntt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MSG   = 8'b0000_0010,
    S_OWN   = 8'b0000_0100,
    S_QRD   = 8'b0000_1000,
    S_QOUT  = 8'b0001_0000,
    S_TDIV  = 8'b0010_0000,
    S_TCNT  = 8'b0100_0000,
    S_SWEEP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          unique case (mode_e'(mode_i))
            MODE_MSG:   state_d = S_MSG;
            MODE_TICK:  state_d = S_TDIV;
            MODE_OWN:   state_d = S_OWN;
            MODE_QUERY: state_d = S_QRD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_MSG: begin
        cmd_o.msg_wr    = 1'b1;
        cmd_o.emit_zero = 1'b1;
        state_d         = S_IDLE;
      end
      S_OWN: begin
        cmd_o.own_wr    = 1'b1;
        cmd_o.emit_zero = 1'b1;
        state_d         = S_IDLE;
      end
      S_QRD: begin
        cmd_o.q_rd = 1'b1;
        state_d    = S_QOUT;
      end
      S_QOUT: begin
        cmd_o.emit_query = 1'b1;
        state_d          = S_IDLE;
      end
      S_TDIV: begin
        cmd_o.t_div = 1'b1;
        state_d     = S_TCNT;
      end
      S_TCNT: begin
        cmd_o.t_cnt = 1'b1;
        state_d     = S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_done) begin
          cmd_o.emit_tick = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> hdl/ntt_dp.sv
// ----------------------------------------------------------------------------
// ntt_dp
// Datapath: configuration, own state, broadcast counter, entry memories with
// valid bits, the pipelined aging sweep and the result registers.
// ----------------------------------------------------------------------------
module ntt_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ntt_pkg::cmd_t          cmd_i,
  output ntt_pkg::status_t       status_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [9:0]             cfg_data_i,
  input  logic [5:0]             peer_id_i,
  input  logic signed [7:0]      peer_previous_group_i,
  input  logic signed [7:0]      peer_group_i,
  input  logic signed [8:0]      update_tag_i,
  output logic                   done_o,
  output logic                   send_update_o,
  output logic signed [7:0]      sent_previous_group_o,
  output logic signed [7:0]      sent_group_o,
  output logic                   found_o,
  output logic signed [7:0]      query_group_o,
  output logic signed [7:0]      query_previous_group_o
);
  import ntt_pkg::*;

  // configuration
  logic [ID_W-1:0]   own_id_q;
  logic [LIFE_W-1:0] live_q;
  logic [CFG_W-1:0]  cmax_q;

  // latched item
  logic [ID_W-1:0]   id_q;
  logic [GRP_W-1:0]  pprev_q;
  logic [GRP_W-1:0]  pgrp_q;
  logic [TAG_W-1:0]  tag_q;

  // own state and counter
  logic [CNT_W-1:0]  counter_q;
  logic              heard_q;
  logic [GRP_W-1:0]  own_grp_q;
  logic [GRP_W-1:0]  own_prev_q;
  logic [QUO_W-1:0]  div_q;
  logic              fire_q;

  // table
  logic [TABLE_SIZE-1:0] valid_q;
  logic [2*GRP_W-1:0]    grp_mem [TABLE_SIZE];
  logic [LIFE_W-1:0]     life_mem [TABLE_SIZE];
  logic [2*GRP_W-1:0]    grp_rd_q;
  logic [LIFE_W-1:0]     life_rd_q;
  logic                  found_q;

  // sweep
  logic [SWP_W-1:0] sweep_q;
  logic             pend_q;
  logic [IDX_W-1:0] widx_q;

  logic [IDX_W-1:0]         id_idx;
  logic [IDX_W-1:0]         own_idx;
  logic                     id_ok;
  logic                     own_ok;
  logic                     msg_ok;
  logic                     msg_wr;
  logic                     own_wr;
  logic                     sw_rd;
  logic                     sw_wr;
  logic                     sw_free;
  logic [2*CNT_W-1:0]       prod;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     fire;
  logic                     gw_en;
  logic [IDX_W-1:0]         gw_idx;
  logic [2*GRP_W-1:0]       gw_data;
  logic                     lw_en;
  logic [IDX_W-1:0]         lw_idx;
  logic [LIFE_W-1:0]        lw_data;

  assign id_idx  = to_idx(id_q);
  assign own_idx = to_idx(own_id_q);
  assign id_ok   = (32'(id_q) < TABLE_SIZE);
  assign own_ok  = (32'(own_id_q) < TABLE_SIZE) && valid_q[own_idx];

  // negative tags never match
  assign msg_ok = (id_q != own_id_q) && !tag_q[TAG_W-1]
                  && (tag_q[LIFE_W-1:0] == live_q);
  assign msg_wr = cmd_i.msg_wr && msg_ok && id_ok;
  assign own_wr = cmd_i.own_wr && own_ok;

  assign sw_rd   = cmd_i.sweep && (sweep_q < SWP_W'(TABLE_SIZE));
  assign sw_wr   = cmd_i.sweep && pend_q && valid_q[widx_q];
  assign sw_free = sw_wr && (life_rd_q == '0);

  assign status_o.sweep_done = (sweep_q == SWP_W'(TABLE_SIZE));

  assign prod    = counter_q * DIV10_MUL;
  assign cnt_nxt = counter_q + (heard_q ? CNT_W'(div_q) : CNT_W'(1));
  assign fire    = (cnt_nxt > CNT_W'(cmax_q));

  always_comb begin
    gw_en   = 1'b0;
    gw_idx  = id_idx;
    gw_data = {(valid_q[id_idx] ? pprev_q : NONE_GROUP), pgrp_q};
    lw_en   = 1'b0;
    lw_idx  = id_idx;
    lw_data = live_q;
    if (msg_wr) begin
      gw_en = 1'b1;
      lw_en = 1'b1;
    end else if (own_wr) begin
      gw_en   = 1'b1;
      gw_idx  = own_idx;
      gw_data = {own_grp_q, pgrp_q};
      lw_en   = 1'b1;
      lw_idx  = own_idx;
    end else if (sw_wr && !sw_free) begin
      lw_en   = 1'b1;
      lw_idx  = widx_q;
      lw_data = life_rd_q - LIFE_W'(1);
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (gw_en) begin
      grp_mem[gw_idx] <= gw_data;
    end
    if (cmd_i.q_rd) begin
      grp_rd_q <= grp_mem[id_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      life_mem[lw_idx] <= lw_data;
    end
    if (sw_rd) begin
      life_rd_q <= life_mem[sweep_q[IDX_W-1:0]];
    end
  end

  // item latch and working registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      id_q    <= peer_id_i;
      pprev_q <= peer_previous_group_i;
      pgrp_q  <= peer_group_i;
      tag_q   <= update_tag_i;
    end
    if (cmd_i.t_div) begin
      div_q <= prod[DIV10_SHIFT +: QUO_W];
    end
    if (cmd_i.t_cnt) begin
      fire_q <= fire;
    end
    if (cmd_i.q_rd) begin
      found_q <= id_ok && valid_q[id_idx];
    end
    if (cmd_i.sweep) begin
      widx_q <= sweep_q[IDX_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q   <= RST_OWN_ID;
      live_q     <= RST_LIVE_TICKS;
      cmax_q     <= RST_COUNT_MAX;
      counter_q  <= CNT_W'(RST_COUNTER_START);
      heard_q    <= 1'b0;
      own_grp_q  <= NONE_GROUP;
      own_prev_q <= NONE_GROUP;
      valid_q    <= '0;
      sweep_q    <= '0;
      pend_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_OWN_ID:        own_id_q  <= cfg_data_i[ID_W-1:0];
          CFG_LIVE_TICKS:    live_q    <= cfg_data_i[LIFE_W-1:0];
          CFG_COUNT_MAX:     cmax_q    <= cfg_data_i;
          CFG_COUNTER_START: counter_q <= CNT_W'(cfg_data_i);
          default: ;
        endcase
      end
      if (cmd_i.msg_wr && msg_ok) begin
        heard_q <= 1'b1;
      end
      if (msg_wr) begin
        valid_q[id_idx] <= 1'b1;
      end
      if (cmd_i.own_wr) begin
        own_prev_q <= own_grp_q;
        own_grp_q  <= pgrp_q;
      end
      if (cmd_i.t_cnt) begin
        counter_q <= fire ? '0 : cnt_nxt;
        heard_q   <= 1'b0;
        sweep_q   <= '0;
        pend_q    <= 1'b0;
      end
      if (cmd_i.sweep) begin
        sweep_q <= sweep_q + SWP_W'(1);
        pend_q  <= sw_rd;
      end
      if (sw_free) begin
        valid_q[widx_q] <= 1'b0;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.emit_zero || cmd_i.emit_query || cmd_i.emit_tick;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_zero || cmd_i.emit_query || cmd_i.emit_tick) begin
      send_update_o          <= 1'b0;
      sent_previous_group_o  <= '0;
      sent_group_o           <= '0;
      found_o                <= 1'b0;
      query_group_o          <= '0;
      query_previous_group_o <= '0;
      if (cmd_i.emit_query && found_q) begin
        found_o                <= 1'b1;
        query_group_o          <= grp_rd_q[GRP_W-1:0];
        query_previous_group_o <= grp_rd_q[2*GRP_W-1:GRP_W];
      end
      if (cmd_i.emit_tick && fire_q) begin
        send_update_o         <= 1'b1;
        sent_previous_group_o <= own_prev_q;
        sent_group_o          <= own_grp_q;
      end
    end
  end

endmodule

>>> hdl/neighbor_table_with_ttl_sync.sv
// A message or own-group change runs one state, a query S_QRD and S_QOUT,
// a tick S_TDIV, S_TCNT and the aging sweep of one entry per cycle.
// The next item is taken as soon as busy drops; the result shows on done_o
// for one cycle right after, and the receiver cannot stall it.
// Reset clears the valid bits at once and loads the register defaults;
// the table is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
// neighbor_table_with_ttl_sync
// Neighbor table indexed by ID with TTL aging and broadcast counter sync.
// ----------------------------------------------------------------------------
module neighbor_table_with_ttl_sync (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [9:0]        cfg_data_i,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [5:0]        peer_id_i,
  input  logic signed [7:0] peer_previous_group_i,
  input  logic signed [7:0] peer_group_i,
  input  logic signed [8:0] update_tag_i,
  output logic              done_o,
  output logic              send_update_o,
  output logic signed [7:0] sent_previous_group_o,
  output logic signed [7:0] sent_group_o,
  output logic              found_o,
  output logic signed [7:0] query_group_o,
  output logic signed [7:0] query_previous_group_o
);
  import ntt_pkg::*;

  cmd_t    cmd;
  status_t status;

  ntt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (mode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  ntt_dp u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .status_o               (status),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .peer_id_i              (peer_id_i),
    .peer_previous_group_i  (peer_previous_group_i),
    .peer_group_i           (peer_group_i),
    .update_tag_i           (update_tag_i),
    .done_o                 (done_o),
    .send_update_o          (send_update_o),
    .sent_previous_group_o  (sent_previous_group_o),
    .sent_group_o           (sent_group_o),
    .found_o                (found_o),
    .query_group_o          (query_group_o),
    .query_previous_group_o (query_previous_group_o)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the neighbor table: a directed opening, then random
// command phases under several register settings. A table model inside the
// bench predicts every result, and a monitor compares the results field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ntt_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 240;
  localparam int TAIL_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  // register settings per random phase, extremes included
  localparam int PH_OWN   [NUM_PHASES] = '{63, 12, 0, 33, 7, 63, 20, 1};
  localparam int PH_LIVE  [NUM_PHASES] = '{3, 255, 1, 10, 200, 2, 128, 6};
  localparam int PH_MAX   [NUM_PHASES] = '{1, 1000, 20, 50, 100, 5, 300, 1};
  localparam int PH_START [NUM_PHASES] = '{0, 1000, 7, 0, 90, 1000, 250, 1};

  typedef struct packed {
    mode_e                   op;
    logic [ID_W-1:0]         id;
    logic signed [GRP_W-1:0] prev_grp;
    logic signed [GRP_W-1:0] grp;
    logic signed [TAG_W-1:0] tag;
  } nt_cmd_t;

  typedef struct packed {
    logic                    fired;
    logic signed [GRP_W-1:0] sent_prev;
    logic signed [GRP_W-1:0] sent_grp;
    logic                    hit;
    logic signed [GRP_W-1:0] q_grp;
    logic signed [GRP_W-1:0] q_prev;
  } nt_rsp_t;

  logic              clk_i;
  logic              rst_ni                 = 1'b0;
  logic              cfg_we_i               = 1'b0;
  logic [1:0]        cfg_idx_i              = '0;
  logic [9:0]        cfg_data_i             = '0;
  logic              start                  = 1'b0;
  logic              busy;
  logic [1:0]        mode_i                 = '0;
  logic [5:0]        peer_id_i              = '0;
  logic signed [7:0] peer_previous_group_i  = '0;
  logic signed [7:0] peer_group_i           = '0;
  logic signed [8:0] update_tag_i           = '0;
  logic              done_o;
  logic              send_update_o;
  logic signed [7:0] sent_previous_group_o;
  logic signed [7:0] sent_group_o;
  logic              found_o;
  logic signed [7:0] query_group_o;
  logic signed [7:0] query_previous_group_o;

  neighbor_table_with_ttl_sync dut (.*);

  // table model state
  logic                nbr_valid [TABLE_SIZE];
  logic [GRP_W-1:0]    nbr_group [TABLE_SIZE];
  logic [GRP_W-1:0]    nbr_prev  [TABLE_SIZE];
  logic [LIFE_W-1:0]   nbr_life  [TABLE_SIZE];
  logic [CNT_W-1:0]    bcast_cnt;
  logic                heard;
  logic [GRP_W-1:0]    my_group;
  logic [GRP_W-1:0]    my_prev;
  logic [ID_W-1:0]     m_own_id;
  logic [LIFE_W-1:0]   m_live;
  logic [CFG_W-1:0]    m_max;

  nt_cmd_t cmd_q [$];
  nt_rsp_t outcome_q [$];
  int      n_queued  = 0;
  int      acc_cnt   = 0;
  int      drv_cnt   = 0;
  int      hold_off  = 0;
  int      idle_pct  = 0;
  int      err_cnt   = 0;
  int      stall_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp);
    if (got !== exp)
      report_error($sformatf("%s is %h, want %h", name, got, exp));
  endtask

  task automatic free_nbr(input int k);
    nbr_valid[k] = 1'b0;
    nbr_group[k] = NONE_GROUP;
    nbr_prev[k]  = NONE_GROUP;
    nbr_life[k]  = '0;
  endtask

  task automatic clear_table();
    for (int k = 0; k < TABLE_SIZE; k++) free_nbr(k);
    m_own_id  = RST_OWN_ID;
    m_live    = RST_LIVE_TICKS;
    m_max     = RST_COUNT_MAX;
    bcast_cnt = CNT_W'(RST_COUNTER_START);
    heard     = 1'b0;
    my_group  = NONE_GROUP;
    my_prev   = NONE_GROUP;
  endtask

  task automatic apply_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    unique case (idx)
      CFG_OWN_ID:        m_own_id  = val[ID_W-1:0];
      CFG_LIVE_TICKS:    m_live    = val[LIFE_W-1:0];
      CFG_COUNT_MAX:     m_max     = val;
      CFG_COUNTER_START: bcast_cnt = CNT_W'(val);
      default: ;
    endcase
  endtask

  task automatic predict_outcome(input nt_cmd_t c, output nt_rsp_t r);
    r = '0;
    case (c.op)
      MODE_MSG: begin
        // negative tags never match, even when the low byte does
        if (c.id != m_own_id && !c.tag[TAG_W-1] && c.tag[LIFE_W-1:0] == m_live) begin
          heard = 1'b1;
          nbr_prev[c.id]  = nbr_valid[c.id] ? c.prev_grp : NONE_GROUP;
          nbr_group[c.id] = c.grp;
          nbr_life[c.id]  = m_live;
          nbr_valid[c.id] = 1'b1;
        end
      end
      MODE_TICK: begin
        bcast_cnt = CNT_W'(heard ? bcast_cnt + bcast_cnt / 10 : bcast_cnt + 1);
        if (bcast_cnt > {1'b0, m_max}) begin
          r.fired     = 1'b1;
          r.sent_prev = my_prev;
          r.sent_grp  = my_group;
          bcast_cnt   = '0;
        end
        for (int k = 0; k < TABLE_SIZE; k++) begin
          if (nbr_valid[k]) begin
            if (nbr_life[k] == 0) free_nbr(k);
            else nbr_life[k]--;
          end
        end
        heard = 1'b0;
      end
      MODE_OWN: begin
        my_prev  = my_group;
        my_group = c.grp;
        if (nbr_valid[m_own_id]) begin
          nbr_prev[m_own_id]  = my_prev;
          nbr_group[m_own_id] = my_group;
          nbr_life[m_own_id]  = m_live;
        end
      end
      default: begin
        if (nbr_valid[c.id]) begin
          r.hit    = 1'b1;
          r.q_grp  = nbr_group[c.id];
          r.q_prev = nbr_prev[c.id];
        end
      end
    endcase
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic nt_cmd_t mk(input mode_e op, input int id, input int pg,
                                 input int g, input int tag);
    nt_cmd_t c;
    c.op       = op;
    c.id       = ID_W'(id);
    c.prev_grp = GRP_W'(pg);
    c.grp      = GRP_W'(g);
    c.tag      = TAG_W'(tag);
    return c;
  endfunction

  function automatic nt_cmd_t rand_cmd(input logic [ID_W-1:0] own,
                                       input logic [LIFE_W-1:0] live);
    nt_cmd_t     c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      c.op = MODE_MSG;
    else if (roll < 65) c.op = MODE_TICK;
    else if (roll < 73) c.op = MODE_OWN;
    else                c.op = MODE_QUERY;
    // a small hot pool of IDs so queries hit live entries
    roll = $urandom_range(0, 99);
    if (roll < 65)      c.id = ID_W'($urandom_range(0, 15));
    else if (roll < 75) c.id = own;
    else                c.id = ID_W'($urandom);
    c.prev_grp = GRP_W'($urandom_range(0, 127) - 1);
    c.grp      = GRP_W'($urandom_range(0, 127) - 1);
    roll = $urandom_range(0, 99);
    if (roll < 80)      c.tag = {1'b0, live};
    else if (roll < 88) c.tag = '1;
    else if (roll < 94) c.tag = {1'b0, live + 8'd1};
    else                c.tag = TAG_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic add_cmd(input nt_cmd_t c);
    cmd_q.push_back(c);
    n_queued++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_drained();
    while (!(acc_cnt == n_queued && outcome_q.size() == 0)) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // driver: holds an item until its transfer, then an optional gap
  always @(negedge clk_i) begin : drive_p
    nt_cmd_t nxt;
    if (rst_ni && !(start && acc_cnt != drv_cnt)) begin
      if (hold_off > 0) begin
        start    <= 1'b0;
        hold_off <= hold_off - 1;
      end else if (cmd_q.size() > 0) begin
        nxt = cmd_q.pop_front();
        mode_i                <= nxt.op;
        peer_id_i             <= nxt.id;
        peer_previous_group_i <= nxt.prev_grp;
        peer_group_i          <= nxt.grp;
        update_tag_i          <= nxt.tag;
        start                 <= 1'b1;
        drv_cnt               <= drv_cnt + 1;
        hold_off              <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: checks results, then tracks register writes and accepted items
  always @(posedge clk_i or negedge rst_ni) begin : monitor_p
    nt_cmd_t got;
    nt_rsp_t want;
    nt_rsp_t res;
    if (!rst_ni) begin
      clear_table();
    end else begin
      if (done_o) begin
        if (outcome_q.size() == 0) begin
          report_error("result with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          check_field("send_update", 8'(send_update_o), 8'(want.fired));
          check_field("sent_previous_group", sent_previous_group_o, want.sent_prev);
          check_field("sent_group", sent_group_o, want.sent_grp);
          check_field("found", 8'(found_o), 8'(want.hit));
          check_field("query_group", query_group_o, want.q_grp);
          check_field("query_previous_group", query_previous_group_o, want.q_prev);
        end
      end
      if (cfg_we_i) apply_reg(cfg_idx_e'(cfg_idx_i), cfg_data_i);
      if (start && !busy) begin
        got.op       = mode_e'(mode_i);
        got.id       = peer_id_i;
        got.prev_grp = peer_previous_group_i;
        got.grp      = peer_group_i;
        got.tag      = update_tag_i;
        predict_outcome(got, res);
        outcome_q.push_back(res);
        acc_cnt++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stim_p
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni   = 1'b1;
    idle_pct = 30;

    // reset settings: own ID 0, life 200, max 100, counter 0
    add_cmd(mk(MODE_QUERY, 5, 0, 0, 0));
    add_cmd(mk(MODE_MSG, 5, 7, 3, 200));       // new entry, previous group none
    add_cmd(mk(MODE_QUERY, 5, 0, 0, 0));
    add_cmd(mk(MODE_MSG, 5, 126, 126, 200));   // existing entry takes previous group
    add_cmd(mk(MODE_QUERY, 5, 0, 0, 0));
    add_cmd(mk(MODE_MSG, 63, -1, -1, 200));
    add_cmd(mk(MODE_QUERY, 63, 0, 0, 0));
    add_cmd(mk(MODE_MSG, 0, 1, 1, 200));       // own ID is ignored
    add_cmd(mk(MODE_QUERY, 0, 0, 0, 0));
    add_cmd(mk(MODE_MSG, 9, 2, 2, 199));       // tag off by one
    add_cmd(mk(MODE_MSG, 9, 2, 2, -1));        // negative tag
    add_cmd(mk(MODE_QUERY, 9, 0, 0, 0));
    add_cmd(mk(MODE_OWN, 0, 0, 17, 0));
    add_cmd(mk(MODE_TICK, 0, 0, 0, 0));        // heard an update: counter grows by /10
    add_cmd(mk(MODE_TICK, 0, 0, 0, 0));
    add_cmd(mk(MODE_OWN, 0, 0, -1, 0));
    add_cmd(mk(MODE_TICK, 63, 126, 126, -1));
    add_cmd(mk(MODE_QUERY, 63, 0, 0, 0));
    wait_drained();

    // own ID moved onto a live entry: own-group change refreshes it
    write_reg(CFG_OWN_ID, 5);
    add_cmd(mk(MODE_OWN, 0, 0, 40, 0));
    add_cmd(mk(MODE_QUERY, 5, 0, 0, 0));
    add_cmd(mk(MODE_MSG, 5, 9, 9, 200));
    add_cmd(mk(MODE_QUERY, 5, 0, 0, 0));
    add_cmd(mk(MODE_TICK, 0, 0, 0, 0));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_OWN_ID, PH_OWN[p]);
      write_reg(CFG_LIVE_TICKS, PH_LIVE[p]);
      write_reg(CFG_COUNT_MAX, PH_MAX[p]);
      write_reg(CFG_COUNTER_START, PH_START[p]);
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 25 : 60;
      for (int n = 0; n < PHASE_ITEMS; n++)
        add_cmd(rand_cmd(ID_W'(PH_OWN[p]), LIFE_W'(PH_LIVE[p])));
      wait_drained();
    end

    if (err_cnt == 0 && outcome_q.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
